FILE: hdl/pfrc_pkg.sv
// ----------------------------------------------------------------------------
// pfrc_pkg: shared types and constants
// Field widths, item kinds, rule codes, register indexes and controller
// command/status structs for the port flag rule connection checker.
// ----------------------------------------------------------------------------
package pfrc_pkg;

  localparam int WORD_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    KIND_RULE  = 2'd0,
    KIND_PORT  = 2'd1,
    KIND_CHECK = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  localparam logic [3:0] RC_EQ   = 4'd0;
  localparam logic [3:0] RC_NE   = 4'd1;
  localparam logic [3:0] RC_BZ   = 4'd2;
  localparam logic [3:0] RC_AND  = 4'd3;
  localparam logic [3:0] RC_OR   = 4'd4;
  localparam logic [3:0] RC_XOR  = 4'd5;
  localparam logic [3:0] RC_NAND = 4'd6;
  localparam logic [3:0] RC_NOR  = 4'd7;
  localparam logic [3:0] RC_XNOR = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ALLOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic rule_wr;    // write rule entry
    logic scan_start; // reset scan pointer
    logic scan_step;  // advance port table scan
    logic port_wr;    // commit port write
    logic clear;      // drop all port table valid bits
    logic rule_start; // reset rule pointer
    logic rule_step;  // evaluate one rule
    logic finish;     // form result
  } pfrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  scan_done;
    logic  rule_done;
  } pfrc_sts_t;

  // one rule against masked flags
  function automatic logic rule_hit(input logic [3:0] code, input logic [WORD_W-1:0] ma,
                                    input logic [WORD_W-1:0] mb);
    logic a;
    logic b;
    a = |ma;
    b = |mb;
    case (code)
      RC_EQ:   rule_hit = (ma == mb);
      RC_NE:   rule_hit = (ma != mb);
      RC_BZ:   rule_hit = !a && !b;
      RC_AND:  rule_hit = a && b;
      RC_OR:   rule_hit = a || b;
      RC_XOR:  rule_hit = a != b;
      RC_NAND: rule_hit = !(a && b);
      RC_NOR:  rule_hit = !(a || b);
      RC_XNOR: rule_hit = a == b;
      default: rule_hit = 1'b0;
    endcase
  endfunction

endpackage

FILE: hdl/pfrc_if.sv
// ----------------------------------------------------------------------------
// pfrc_in_if / pfrc_out_if: valid-ready channels
// Input item and result item channels of the connection checker.
// ----------------------------------------------------------------------------
interface pfrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        rule_pass;
  logic [3:0]  rule_slot;
  logic [3:0]  rule_code;
  logic [31:0] mask_first_side;
  logic [31:0] mask_second_side;
  logic [31:0] port_number;
  logic [31:0] port_flag_bits;
  logic [31:0] source_port;
  logic [31:0] dest_port;
  logic        batch_last;
  modport source (output valid, kind, rule_pass, rule_slot, rule_code, mask_first_side,
                  mask_second_side, port_number, port_flag_bits, source_port, dest_port,
                  batch_last, input ready);
  modport sink (input valid, kind, rule_pass, rule_slot, rule_code, mask_first_side,
                mask_second_side, port_number, port_flag_bits, source_port, dest_port,
                batch_last, output ready);
endinterface

interface pfrc_out_if;
  logic        valid;
  logic        ready;
  logic        allowed;
  logic        batch_allowed;
  logic        batch_end;
  logic [31:0] source_flags_seen;
  logic [31:0] dest_flags_seen;
  logic        status;
  modport source (output valid, allowed, batch_allowed, batch_end, source_flags_seen,
                  dest_flags_seen, status, input ready);
  modport sink (input valid, allowed, batch_allowed, batch_end, source_flags_seen,
                dest_flags_seen, status, output ready);
endinterface

FILE: hdl/pfrc_ctrl.sv
// ----------------------------------------------------------------------------
// pfrc_ctrl: sequencing state machine
// Accepts one beat; walks the port table for port writes and checks, then
// the rules for checks, then presents the result until it is taken.
// ----------------------------------------------------------------------------
module pfrc_ctrl
  import pfrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pfrc_sts_t sts,
  output pfrc_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEC  = 6'b000010,
    S_SCAN = 6'b000100,
    S_RULE = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_DEC;
      end
      S_DEC: begin
        cmd.scan_start = 1'b1;
        unique case (sts.kind)
          KIND_RULE:  begin cmd.rule_wr = 1'b1; state_next = S_FIN; end
          KIND_CLEAR: begin cmd.clear = 1'b1; state_next = S_FIN; end
          default:    state_next = S_SCAN;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.scan_step = 1'b0;
          cmd.rule_start = 1'b1;
          if (sts.kind == KIND_PORT) begin
            cmd.port_wr = 1'b1;
            state_next = S_FIN;
          end else begin
            state_next = S_RULE;
          end
        end
      end
      S_RULE: begin
        cmd.rule_step = !sts.rule_done;
        if (sts.rule_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

FILE: hdl/pfrc_datapath.sv
// ----------------------------------------------------------------------------
// pfrc_datapath: rule banks, port table and verdict logic
// One port table entry compared per cycle, one rule evaluated per cycle.
// ----------------------------------------------------------------------------
module pfrc_datapath
  import pfrc_pkg::*;
#(
  parameter int RULES_PER_PASS = 16,
  parameter int PORT_ENTRIES   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pfrc_cmd_t             cmd,
  output pfrc_sts_t             sts,
  input  logic                  cfg_default_allow,
  input  logic [4:0]            cfg_first_count,
  input  logic [4:0]            cfg_second_count,
  input  logic                  cfg_check_enable,
  pfrc_in_if.sink               in_ch,
  output logic                  allowed,
  output logic                  batch_allowed,
  output logic                  batch_end,
  output logic [WORD_W-1:0]     source_flags_seen,
  output logic [WORD_W-1:0]     dest_flags_seen,
  output logic                  status
);

  localparam int RULE_TOTAL = 2 * RULES_PER_PASS;
  localparam int RI_W = $clog2(RULE_TOTAL);
  localparam int RC_W = $clog2(RULES_PER_PASS + 1);
  localparam int PI_W = $clog2(PORT_ENTRIES);
  localparam int PC_W = $clog2(PORT_ENTRIES + 1);
  localparam int CW = (RC_W > 5) ? RC_W : 5;

  // captured beat
  kind_t             kind;
  logic              r_pass;
  logic [3:0]        r_slot;
  logic [3:0]        r_code;
  logic [WORD_W-1:0] m_first, m_second, p_num, p_flags, s_port, d_port;
  logic              last;

  // rule banks (memories, registered read)
  logic [3:0]        rule_code_mem [RULE_TOTAL];
  logic [WORD_W-1:0] rule_ma_mem   [RULE_TOTAL];
  logic [WORD_W-1:0] rule_mb_mem   [RULE_TOTAL];
  logic [RULE_TOTAL-1:0] rule_valid;

  // port table (memories, registered read)
  logic [WORD_W-1:0] port_id_mem   [PORT_ENTRIES];
  logic [WORD_W-1:0] port_flag_mem [PORT_ENTRIES];
  logic [PORT_ENTRIES-1:0] port_valid;

  // scan state
  logic [PC_W-1:0]   scan_cnt;
  logic              rd_ok;
  logic [PI_W-1:0]   rd_idx;
  logic              rd_valid;
  logic [WORD_W-1:0] rd_id, rd_flags;
  logic              s_found, d_found, hit_found, free_found;
  logic [PI_W-1:0]   hit_idx, free_idx;
  logic [WORD_W-1:0] s_flags, d_flags;

  // rule walk state
  logic              bank;
  logic [RC_W-1:0]   rcnt;
  logic [RC_W-1:0]   n_first, n_second;
  logic              rr_ok;
  logic              rr_vld;
  logic              rr_hit;
  logic [3:0]        rr_code;
  logic [WORD_W-1:0] rr_ma, rr_mb;
  logic              toggle;
  logic              running_ok;
  logic              rule_in_range;
  logic [RI_W-1:0]   rule_wr_idx, rule_rd_idx;
  logic              verdict;

  // clamp counts to bank size
  localparam logic [CW-1:0] RPP = CW'(RULES_PER_PASS);
  assign n_first  = (CW'(cfg_first_count) > RPP) ? RC_W'(RULES_PER_PASS)
                                                 : RC_W'(cfg_first_count);
  assign n_second = (CW'(cfg_second_count) > RPP) ? RC_W'(RULES_PER_PASS)
                                                  : RC_W'(cfg_second_count);

  assign rule_in_range = ({1'b0, r_slot} < 5'(RULES_PER_PASS)) || (RULES_PER_PASS > 16);
  assign rule_wr_idx = RI_W'(r_pass ? (RULES_PER_PASS + int'(r_slot)) : int'(r_slot));
  assign rule_rd_idx = RI_W'(bank ? (RULES_PER_PASS + int'(rcnt)) : int'(rcnt));

  // capture beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= kind_t'(in_ch.kind);
      r_pass   <= in_ch.rule_pass;
      r_slot   <= in_ch.rule_slot;
      r_code   <= in_ch.rule_code;
      m_first  <= in_ch.mask_first_side;
      m_second <= in_ch.mask_second_side;
      p_num    <= in_ch.port_number;
      p_flags  <= in_ch.port_flag_bits;
      s_port   <= in_ch.source_port;
      d_port   <= in_ch.dest_port;
      last     <= in_ch.batch_last;
    end
  end

  // rule bank write and read
  always_ff @(posedge clk) begin
    if (cmd.rule_wr && rule_in_range) begin
      rule_code_mem[rule_wr_idx] <= r_code;
      rule_ma_mem[rule_wr_idx]   <= m_first;
      rule_mb_mem[rule_wr_idx]   <= m_second;
    end
    rr_code <= rule_code_mem[rule_rd_idx];
    rr_ma   <= rule_ma_mem[rule_rd_idx];
    rr_mb   <= rule_mb_mem[rule_rd_idx];
    rr_vld  <= rule_valid[rule_rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) rule_valid <= '0;
    else if (cmd.rule_wr && rule_in_range) rule_valid[rule_wr_idx] <= 1'b1;
  end

  // an unwritten rule (valid bit clear) counts as a match, as code 0 with zero masks would
  assign rr_hit = rr_vld ? rule_hit(rr_code, s_flags & rr_ma, d_flags & rr_mb) : 1'b1;

  // port table write and read
  always_ff @(posedge clk) begin
    if (cmd.port_wr && (hit_found || free_found)) begin
      port_id_mem[hit_found ? hit_idx : free_idx]   <= p_num;
      port_flag_mem[hit_found ? hit_idx : free_idx] <= p_flags;
    end
    rd_id    <= port_id_mem[PI_W'(scan_cnt)];
    rd_flags <= port_flag_mem[PI_W'(scan_cnt)];
    rd_idx   <= PI_W'(scan_cnt);
    rd_valid <= port_valid[PI_W'(scan_cnt)];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) port_valid <= '0;
    else if (cmd.port_wr && (hit_found || free_found))
      port_valid[hit_found ? hit_idx : free_idx] <= 1'b1;
  end

  // port table scan, one entry per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_cnt   <= '0;
      rd_ok      <= 1'b0;
      s_found    <= 1'b0;
      d_found    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      s_flags    <= '0;
      d_flags    <= '0;
      hit_idx    <= '0;
      free_idx   <= '0;
    end else if (cmd.scan_step) begin
      if (scan_cnt != PC_W'(PORT_ENTRIES)) scan_cnt <= scan_cnt + 1'b1;
      rd_ok <= (scan_cnt != PC_W'(PORT_ENTRIES));
      if (rd_ok) begin
        if (rd_valid && rd_id == s_port && !s_found) begin
          s_found <= 1'b1;
          s_flags <= rd_flags;
        end
        if (rd_valid && rd_id == d_port && !d_found) begin
          d_found <= 1'b1;
          d_flags <= rd_flags;
        end
        if (rd_valid && rd_id == p_num && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= rd_idx;
        end
        if (!rd_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  assign sts.kind      = kind;
  assign sts.scan_done = (scan_cnt == PC_W'(PORT_ENTRIES)) && !rd_ok && cmd.scan_step == 1'b1
                         ? 1'b1 : ((scan_cnt == PC_W'(PORT_ENTRIES)) && !rd_ok);

  // rule walk: address then evaluate, one rule per cycle
  always_ff @(posedge clk) begin
    if (cmd.rule_start) begin
      bank   <= 1'b0;
      rcnt   <= '0;
      rr_ok  <= 1'b0;
      toggle <= 1'b0;
    end else if (cmd.rule_step) begin
      rr_ok <= 1'b0;
      if (!bank && rcnt != n_first) begin
        rcnt <= rcnt + 1'b1;
        rr_ok <= 1'b1;
      end else if (!bank) begin
        bank <= 1'b1;
        rcnt <= '0;
      end else if (rcnt != n_second) begin
        rcnt <= rcnt + 1'b1;
        rr_ok <= 1'b1;
      end
      if (rr_ok && rr_hit) toggle <= !toggle;
    end
  end

  assign sts.rule_done = bank && (rcnt == n_second) && !rr_ok;

  // result and batch state
  assign verdict = !cfg_check_enable || (cfg_default_allow ^ toggle);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_ok <= 1'b1;
    end else if (cmd.finish && kind == KIND_CHECK) begin
      running_ok <= last ? 1'b1 : (running_ok && verdict);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      allowed           <= (kind == KIND_CHECK) ? verdict : 1'b1;
      batch_allowed     <= (kind == KIND_CHECK) ? (running_ok && verdict) : running_ok;
      batch_end         <= (kind == KIND_CHECK) && last;
      source_flags_seen <= (kind == KIND_CHECK) ? s_flags : '0;
      dest_flags_seen   <= (kind == KIND_CHECK) ? d_flags : '0;
      status            <= (kind == KIND_PORT) && !hit_found && !free_found;
    end
  end

endmodule

FILE: hdl/port_flag_rule_connection_checker.sv
// ----------------------------------------------------------------------------
// port_flag_rule_connection_checker: masked flag rule connection checker
// Port table lookup and two banks of rules toggle a default verdict.
//
//   channel  dir  beat
//   in_ch    in   one item: rule write, port write, check or clear
//   out_ch   out  one result per item
//   cfg      in   register write, index and data
//
// rule and clear items skip the port table scan; port writes run the
// one-entry-per-cycle table scan; checks run that scan and then the
// one-rule-per-cycle walk over both clamped rule counts; output stalls
// lengthen each.
// synchronous reset clears valid bits, returns config registers to defaults and sets the batch AND.
// a stalled result holds the block; the next item is taken once it leaves.
// ----------------------------------------------------------------------------
module port_flag_rule_connection_checker
  import pfrc_pkg::*;
#(
  parameter int RULES_PER_PASS = 16,
  parameter int PORT_ENTRIES   = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pfrc_in_if.sink               in_ch,
  pfrc_out_if.source            out_ch
);

  pfrc_cmd_t  cmd;
  pfrc_sts_t  sts;
  logic       default_allow, check_enable;
  logic [4:0] first_pass_count, second_pass_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_allow     <= 1'b1;
      first_pass_count  <= '0;
      second_pass_count <= '0;
      check_enable      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_ALLOW: default_allow     <= cfg_data[0];
        REG_FIRST_COUNT:   first_pass_count  <= cfg_data;
        REG_SECOND_COUNT:  second_pass_count <= cfg_data;
        REG_CHECK_ENABLE:  check_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfrc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  pfrc_datapath #(.RULES_PER_PASS(RULES_PER_PASS), .PORT_ENTRIES(PORT_ENTRIES)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_default_allow(default_allow), .cfg_first_count(first_pass_count),
    .cfg_second_count(second_pass_count), .cfg_check_enable(check_enable),
    .in_ch,
    .allowed(out_ch.allowed), .batch_allowed(out_ch.batch_allowed),
    .batch_end(out_ch.batch_end), .source_flags_seen(out_ch.source_flags_seen),
    .dest_flags_seen(out_ch.dest_flags_seen), .status(out_ch.status)
  );

  // never accept and present at once
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
  // accepted beat leads to busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("ready after accept");
  // status, raised only on port writes, never comes with batch_end
  a_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status) |-> !out_ch.batch_end) else $error("bad status");

endmodule

FILE: tb/port_flag_rule_connection_checker_test.sv
// ----------------------------------------------------------------------------
// port_flag_rule_connection_checker_test: self-checking bench
// Drives rule writes, port table writes, connection checks and table clears
// through the item channel, predicts every result with an independent model
// of the rule banks and port table, and compares each result beat by field.
// ----------------------------------------------------------------------------
module port_flag_rule_connection_checker_test;
  import pfrc_pkg::*;

  localparam int NRULES = 16;
  localparam int NPORTS = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        allowed;
    logic        batch_allowed;
    logic        batch_end;
    logic [31:0] s_seen;
    logic [31:0] d_seen;
    logic        status;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pfrc_in_if in_ch ();
  pfrc_out_if out_ch ();

  port_flag_rule_connection_checker #(.RULES_PER_PASS(NRULES), .PORT_ENTRIES(NPORTS)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // predictor state
  logic        m_default;
  logic [4:0]  m_count1;
  logic [4:0]  m_count2;
  logic        m_enable;
  logic [3:0]  m_code[2*NRULES];
  logic [31:0] m_mask_a[2*NRULES];
  logic [31:0] m_mask_b[2*NRULES];
  logic        m_valid[NPORTS];
  logic [31:0] m_id[NPORTS];
  logic [31:0] m_flags[NPORTS];
  logic        m_batch_ok;

  verdict_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int checks_sent = 0;
  bit idle_en = 1'b1;

  // known ids so lookups hit often
  logic [31:0] id_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                               32'h1234_5678, 32'hA5A5_A5A5, 32'h7, 32'h55};

  function automatic logic rule_fires(int idx, logic [31:0] s, logic [31:0] d);
    logic [31:0] ma;
    logic [31:0] mb;
    logic a;
    logic b;
    ma = s & m_mask_a[idx];
    mb = d & m_mask_b[idx];
    a = ma != 0;
    b = mb != 0;
    case (m_code[idx])
      RC_EQ:   return ma == mb;
      RC_NE:   return ma != mb;
      RC_BZ:   return !a && !b;
      RC_AND:  return a && b;
      RC_OR:   return a || b;
      RC_XOR:  return a != b;
      RC_NAND: return !(a && b);
      RC_NOR:  return !(a || b);
      RC_XNOR: return a == b;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic bank_parity(int base, logic [4:0] cnt, logic [31:0] s,
                                       logic [31:0] d);
    logic t;
    int n;
    t = 1'b0;
    n = (cnt > NRULES) ? NRULES : cnt;
    for (int i = 0; i < n; i++) if (rule_fires(base + i, s, d)) t = ~t;
    return t;
  endfunction

  function automatic int port_slot(logic [31:0] id);
    for (int i = 0; i < NPORTS; i++) if (m_valid[i] && m_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [31:0] port_lookup(logic [31:0] id);
    int i;
    i = port_slot(id);
    return (i < 0) ? 32'h0 : m_flags[i];
  endfunction

  // predict the result of one item and update the model
  function automatic verdict_t predict_verdict(kind_t k, logic pass, logic [3:0] slot,
      logic [3:0] code, logic [31:0] ma, logic [31:0] mb, logic [31:0] pnum,
      logic [31:0] pflags, logic [31:0] sp, logic [31:0] dp, logic last);
    verdict_t r;
    int i;
    logic v;
    r = '0;
    r.allowed = 1'b1;
    r.batch_allowed = m_batch_ok;
    case (k)
      KIND_RULE: begin
        i = pass * NRULES + slot;
        m_code[i] = code;
        m_mask_a[i] = ma;
        m_mask_b[i] = mb;
      end
      KIND_PORT: begin
        i = port_slot(pnum);
        if (i < 0) for (int j = 0; j < NPORTS; j++) if (!m_valid[j]) begin
          i = j;
          break;
        end
        if (i < 0) r.status = 1'b1;
        else begin
          m_valid[i] = 1'b1;
          m_id[i] = pnum;
          m_flags[i] = pflags;
        end
      end
      KIND_CHECK: begin
        r.s_seen = port_lookup(sp);
        r.d_seen = port_lookup(dp);
        v = m_default ^ bank_parity(0, m_count1, r.s_seen, r.d_seen)
                      ^ bank_parity(NRULES, m_count2, r.s_seen, r.d_seen);
        if (!m_enable) v = 1'b1;
        r.allowed = v;
        r.batch_allowed = m_batch_ok & v;
        r.batch_end = last;
        m_batch_ok = last ? 1'b1 : r.batch_allowed;
      end
      default: for (int j = 0; j < NPORTS; j++) m_valid[j] = 1'b0;
    endcase
    return r;
  endfunction

  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
  endtask

  // send one item and queue its expected result
  task automatic send_item(kind_t k, logic pass, logic [3:0] slot, logic [3:0] code,
      logic [31:0] ma, logic [31:0] mb, logic [31:0] pnum, logic [31:0] pflags,
      logic [31:0] sp, logic [31:0] dp, logic last);
    idle_gap();
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.rule_pass <= pass;
    in_ch.rule_slot <= slot;
    in_ch.rule_code <= code;
    in_ch.mask_first_side <= ma;
    in_ch.mask_second_side <= mb;
    in_ch.port_number <= pnum;
    in_ch.port_flag_bits <= pflags;
    in_ch.source_port <= sp;
    in_ch.dest_port <= dp;
    in_ch.batch_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(predict_verdict(k, pass, slot, code, ma, mb, pnum, pflags,
                                         sp, dp, last));
    if (k == KIND_CHECK) checks_sent++;
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_rule(logic pass, logic [3:0] slot, logic [3:0] code,
                           logic [31:0] ma, logic [31:0] mb);
    send_item(KIND_RULE, pass, slot, code, ma, mb, $urandom, $urandom, $urandom,
              $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_port(logic [31:0] id, logic [31:0] flags);
    send_item(KIND_PORT, 1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom), $urandom,
              $urandom, id, flags, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_check(logic [31:0] sp, logic [31:0] dp, logic last);
    send_item(KIND_CHECK, 1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom), $urandom,
              $urandom, $urandom, $urandom, sp, dp, last);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, 1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom), $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // register write only once the block has drained
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEFAULT_ALLOW: m_default = val[0];
      REG_FIRST_COUNT:   m_count1 = val;
      REG_SECOND_COUNT:  m_count2 = val;
      REG_CHECK_ENABLE:  m_enable = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_id();
    return ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 7)] : $urandom;
  endfunction

  task automatic rand_item();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 3)
      send_rule(1'($urandom_range(0, 1)), 4'($urandom), 4'($urandom_range(0, 15)),
                $urandom_range(0, 1) ? $urandom : (32'h1 << $urandom_range(0, 31)),
                $urandom_range(0, 1) ? $urandom : (32'h1 << $urandom_range(0, 31)));
    else if (sel < 7) send_port(pick_id(), $urandom_range(0, 3) ? $urandom : 32'h0);
    else if (sel < 19) send_check(pick_id(), pick_id(), $urandom_range(0, 3) == 0);
    else if ($urandom_range(0, 3) == 0) send_clear();
    else send_check(pick_id(), pick_id(), 1'b1);
  endtask

  // test: every rule code and field extremes
  task automatic test_directed();
    for (int c = 0; c < 10; c++)
      send_rule(c[0], c[3:0], (c == 9) ? 4'd15 : c[3:0], 32'hFFFF_FFFF, 32'h0000_FFFF);
    send_port(32'h0, 32'hFFFF_FFFF);
    send_port(32'hFFFF_FFFF, 32'h0000_0001);
    send_port(32'hFFFF_FFFF, 32'h8000_0000);
    send_check(32'h0, 32'hFFFF_FFFF, 1'b0);
    send_check(32'hFFFF_FFFF, 32'h1234, 1'b0);
    send_check(32'h5, 32'h0, 1'b1);
    write_reg(REG_FIRST_COUNT, 5'd16);
    write_reg(REG_SECOND_COUNT, 5'd31);
    send_check(32'h0, 32'hFFFF_FFFF, 1'b0);
    send_check(32'hFFFF_FFFF, 32'h0, 1'b1);
    write_reg(REG_CHECK_ENABLE, 5'd0);
    write_reg(REG_DEFAULT_ALLOW, 5'd0);
    send_check(32'h0, 32'h0, 1'b1);
    send_clear();
    send_check(32'h0, 32'hFFFF_FFFF, 1'b1);
    write_reg(REG_CHECK_ENABLE, 5'd1);
  endtask

  // test: fill the table, overflow it, overwrite and clear
  task automatic test_table_full();
    for (int i = 0; i < NPORTS; i++) send_port(32'h100 + i, $urandom);
    send_port(32'hDEAD_0000, 32'h1);
    send_port(32'h100 + 7, 32'hFFFF_0000);
    send_check(32'h107, 32'h13F, 1'b1);
    send_clear();
    send_port(32'hDEAD_0000, 32'h2);
  endtask

  // test: random traffic over several register settings
  task automatic test_random(int n);
    logic [4:0] counts[5] = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_DEFAULT_ALLOW, 5'($urandom_range(0, 1)));
      write_reg(REG_FIRST_COUNT, (p < 5) ? counts[p] : 5'($urandom_range(0, 31)));
      write_reg(REG_SECOND_COUNT, (p < 5) ? counts[4 - p] : 5'($urandom_range(0, 31)));
      write_reg(REG_CHECK_ENABLE, 5'((p % 4) != 3));
      if (p == 7) idle_en = 1'b0;
      for (int i = 0; i < n / 8; i++) begin
        if (i == n / 16 && p == 2) while (expected_q.size() != 0) @(negedge clk);
        rand_item();
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp_v;
    if (!rst) begin
      cycles <= cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.allowed, out_ch.batch_allowed, out_ch.batch_end,
                out_ch.source_flags_seen, out_ch.dest_flags_seen, out_ch.status};
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_v = expected_q.pop_front();
          if (got.allowed !== exp_v.allowed) begin
            $error("allowed exp %0d got %0d", exp_v.allowed, got.allowed); errors++;
          end
          if (got.batch_allowed !== exp_v.batch_allowed) begin
            $error("batch_allowed exp %0d got %0d", exp_v.batch_allowed, got.batch_allowed);
            errors++;
          end
          if (got.batch_end !== exp_v.batch_end) begin
            $error("batch_end exp %0d got %0d", exp_v.batch_end, got.batch_end); errors++;
          end
          if (got.s_seen !== exp_v.s_seen) begin
            $error("source_flags_seen exp %h got %h", exp_v.s_seen, got.s_seen);
            errors++;
          end
          if (got.d_seen !== exp_v.d_seen) begin
            $error("dest_flags_seen exp %h got %h", exp_v.d_seen, got.d_seen);
            errors++;
          end
          if (got.status !== exp_v.status) begin
            $error("status exp %0d got %0d", exp_v.status, got.status); errors++;
          end
        end
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_RULE;
    in_ch.rule_pass = 1'b0;
    in_ch.rule_slot = '0;
    in_ch.rule_code = '0;
    in_ch.mask_first_side = '0;
    in_ch.mask_second_side = '0;
    in_ch.port_number = '0;
    in_ch.port_flag_bits = '0;
    in_ch.source_port = '0;
    in_ch.dest_port = '0;
    in_ch.batch_last = 1'b0;
    m_default = 1'b1;
    m_count1 = '0;
    m_count2 = '0;
    m_enable = 1'b1;
    m_batch_ok = 1'b1;
    for (int i = 0; i < 2 * NRULES; i++) begin
      m_code[i] = '0; m_mask_a[i] = '0; m_mask_b[i] = '0;
    end
    for (int i = 0; i < NPORTS; i++) begin
      m_valid[i] = 1'b0; m_id[i] = '0; m_flags[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_table_full();
    test_random(1560);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("covered rule codes, table overflow and clear, batches; %0d checks", checks_sent);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pfrc_pkg.sv
hdl/pfrc_if.sv
hdl/pfrc_ctrl.sv
hdl/pfrc_datapath.sv
hdl/port_flag_rule_connection_checker.sv
tb/port_flag_rule_connection_checker_test.sv
